[src/rc4_stream_cipher_macros.svh]
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Shorthand for the concurrent checks of the cipher, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication.
`define RC4_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define RC4_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[src/rc4_pkg.sv]
// ----------------------------------------------------------------------------
// RC4 package
// Byte type, operation and status codes, and the control structs passed
// between the top level and the permutation engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

	localparam int BYTE_W     = 8;
	localparam int SBOX_DEPTH = 256;

	typedef logic [BYTE_W-1:0] byte_t;

	localparam byte_t SBOX_LAST = 8'hFF;

	// Operation codes of an input item.
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_DATA_OK  = 2'd0;
	localparam logic [1:0] STAT_KEY_OK   = 2'd1;
	localparam logic [1:0] STAT_KEY_LONG = 2'd2;
	localparam logic [1:0] STAT_NO_KEY   = 2'd3;

	typedef struct packed {
		logic  start_data;
		logic  start_sched;
		byte_t data_byte;
	} eng_req_t;

	typedef struct packed {
		logic  done;
		byte_t out_byte;
	} eng_rsp_t;

endpackage

[src/rc4_req_if.sv]
// ----------------------------------------------------------------------------
// RC4 request channel
// Valid/ready channel that carries one input item: operation, byte and the
// last-key-byte flag.
// ----------------------------------------------------------------------------
interface rc4_req_if import rc4_pkg::*; ();

	logic  valid;
	logic  ready;
	logic  op;
	byte_t byte_in;
	logic  key_last;

	modport source (output valid, output op, output byte_in, output key_last, input ready);
	modport sink   (input valid, input op, input byte_in, input key_last, output ready);

endinterface

[src/rc4_rsp_if.sv]
// ----------------------------------------------------------------------------
// RC4 response channel
// Valid/ready channel that carries one result item: output byte and status.
// ----------------------------------------------------------------------------
interface rc4_rsp_if import rc4_pkg::*; ();

	logic       valid;
	logic       ready;
	byte_t      out_byte;
	logic [1:0] status;

	modport source (output valid, output out_byte, output status, input ready);
	modport sink   (input valid, input out_byte, input status, output ready);

endinterface

[src/rc4_ram.sv]
// ----------------------------------------------------------------------------
// RC4 generic RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/rc4_engine.sv]
// ----------------------------------------------------------------------------
// RC4 permutation engine
// Holds the permutation in a RAM together with the indices i and j. Runs the
// key schedule (fill, then 256 read-modify-write swap steps) and the
// keystream step for one data byte.
// ----------------------------------------------------------------------------
module rc4_engine import rc4_pkg::*; #(
	parameter int KS_AW = 8,
	parameter int CNT_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  eng_req_t         req,
	input  logic [CNT_W-1:0] key_len,
	output logic [KS_AW-1:0] key_raddr,
	input  byte_t            key_rdata,
	output eng_rsp_t         rsp
);

	typedef enum logic [3:0] {
		E_IDLE,
		E_INIT,
		E_K0,
		E_K1,
		E_K2,
		E_K3,
		E_D1,
		E_D2,
		E_D3
	} eng_state_t;

	eng_state_t       st_q;
	byte_t            n_q;
	logic [KS_AW-1:0] kp_q;
	logic [CNT_W-1:0] len_q;
	byte_t            acc_q;
	byte_t            i_q;
	byte_t            j_q;
	byte_t            si_q;
	byte_t            sj_q;
	byte_t            t_q;
	byte_t            byte_q;

	logic  s_we;
	byte_t s_waddr;
	byte_t s_wdata;
	byte_t s_raddr;
	byte_t s_rdata;

	byte_t acc_nx;
	byte_t j_nx;
	byte_t t_nx;
	byte_t ks_byte;
	logic  kp_last;

	assign acc_nx  = byte_t'(acc_q + s_rdata + key_rdata);
	assign j_nx    = byte_t'(j_q + s_rdata);
	assign t_nx    = byte_t'(si_q + s_rdata);
	assign kp_last = (CNT_W'(kp_q) + CNT_W'(1)) == len_q;

	// The output entry may be one of the two just swapped; the j write is
	// the later one, so it wins when both indices meet.
	always_comb begin
		priority if (t_q == j_q) begin
			ks_byte = si_q;
		end else if (t_q == i_q) begin
			ks_byte = sj_q;
		end else begin
			ks_byte = s_rdata;
		end
	end

	always_comb begin
		s_we    = 1'b0;
		s_waddr = n_q;
		s_wdata = n_q;
		s_raddr = byte_t'(i_q + 8'd1);
		unique case (st_q)
			E_IDLE: begin
				s_raddr = byte_t'(i_q + 8'd1);
			end
			E_INIT: begin
				s_we = 1'b1;
			end
			E_K0: begin
				s_raddr = n_q;
			end
			E_K1: begin
				s_raddr = acc_nx;
			end
			E_K2: begin
				s_we    = 1'b1;
				s_wdata = s_rdata;
			end
			E_K3: begin
				s_we    = 1'b1;
				s_waddr = acc_q;
				s_wdata = si_q;
			end
			E_D1: begin
				s_raddr = j_nx;
			end
			E_D2: begin
				s_we    = 1'b1;
				s_waddr = i_q;
				s_wdata = s_rdata;
				s_raddr = t_nx;
			end
			E_D3: begin
				s_we    = 1'b1;
				s_waddr = j_q;
				s_wdata = si_q;
			end
			default: begin
				s_we = 1'b0;
			end
		endcase
	end

	assign key_raddr    = kp_q;
	assign rsp.done     = (st_q == E_D3) || (st_q == E_K3 && n_q == SBOX_LAST);
	assign rsp.out_byte = (st_q == E_D3) ? (byte_q ^ ks_byte) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= E_IDLE;
			i_q  <= '0;
			j_q  <= '0;
		end else begin
			unique case (st_q)
				E_IDLE: begin
					if (req.start_data) begin
						i_q    <= byte_t'(i_q + 8'd1);
						byte_q <= req.data_byte;
						st_q   <= E_D1;
					end else if (req.start_sched) begin
						n_q   <= '0;
						len_q <= key_len;
						st_q  <= E_INIT;
					end
				end
				E_INIT: begin
					n_q <= byte_t'(n_q + 8'd1);
					if (n_q == SBOX_LAST) begin
						acc_q <= '0;
						kp_q  <= '0;
						st_q  <= E_K0;
					end
				end
				E_K0: begin
					st_q <= E_K1;
				end
				E_K1: begin
					si_q  <= s_rdata;
					acc_q <= acc_nx;
					st_q  <= E_K2;
				end
				E_K2: begin
					st_q <= E_K3;
				end
				E_K3: begin
					n_q  <= byte_t'(n_q + 8'd1);
					kp_q <= kp_last ? '0 : KS_AW'(kp_q + KS_AW'(1));
					if (n_q == SBOX_LAST) begin
						i_q  <= '0;
						j_q  <= '0;
						st_q <= E_IDLE;
					end else begin
						st_q <= E_K0;
					end
				end
				E_D1: begin
					si_q <= s_rdata;
					j_q  <= j_nx;
					st_q <= E_D2;
				end
				E_D2: begin
					sj_q <= s_rdata;
					t_q  <= t_nx;
					st_q <= E_D3;
				end
				E_D3: begin
					st_q <= E_IDLE;
				end
				default: begin
					st_q <= E_IDLE;
				end
			endcase
		end
	end

	rc4_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(SBOX_DEPTH)
	) u_sbox_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

endmodule

[src/rc4_stream_cipher.sv]
// A data byte runs the engine's keystream step, with its dependent permutation RAM reads of
// S[i], S[j] and S[S[i]+S[j]], before its result item is registered; no item is taken meanwhile.
// Key bytes that start no schedule (and data sent while unkeyed) are answered on acceptance.
// A closing key byte of legal length runs the schedule: a 256-entry fill, then 256 swap steps.
// Reset (arst_n low, asynchronous) leaves the cipher unkeyed with i, j and key count at zero.
// The permutation and key RAMs are not cleared; they are always written before being read.
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Byte-wide RC4 engine. Key bytes fill a key RAM; the last key byte starts
// the key schedule, after which data bytes are XORed with the keystream.
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher import rc4_pkg::*; #(
	parameter int KEY_MAX = 256
) (
	input  logic   clk,
	input  logic   arst_n,
	rc4_req_if.sink   req,
	rc4_rsp_if.source rsp
);

	// Key RAM addressing and the key byte counter. The counter can hold
	// KEY_MAX + 1, which marks a key that has grown too long.
	localparam int KS_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int CNT_W = $clog2(KEY_MAX + 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(KEY_MAX);
	localparam logic [CNT_W-1:0] CNT_OVF = CNT_W'(KEY_MAX + 1);

	// The control sequencer: idle and ready for an item, waiting on the
	// engine, or holding a result while the output register is still full.
	typedef enum logic [1:0] {
		T_IDLE,
		T_RUN,
		T_PEND
	} top_state_t;

	top_state_t       st_q;
	logic             keyed_q;
	logic [CNT_W-1:0] count_q;
	logic             sched_q;
	logic             out_v_q;
	byte_t            out_byte_q;
	logic [1:0]       out_stat_q;
	byte_t            pend_byte_q;
	logic [1:0]       pend_stat_q;

	logic             in_fire;
	logic             is_key;
	logic             is_data;
	logic             key_room;
	logic             key_wr;
	logic             start_data;
	logic             start_sched;
	logic             out_free;
	logic             res_v;
	byte_t            res_byte;
	logic [1:0]       res_stat;

	eng_req_t         eng_req;
	eng_rsp_t         eng_rsp;
	logic [KS_AW-1:0] key_raddr;
	byte_t            key_rdata;

	// An item is taken whenever no earlier item is at work and none is parked. A
	// finished result may sit in the output register meanwhile; the next result
	// then parks in the pending register until the output frees up.
	assign req.ready = (st_q == T_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign is_key    = in_fire && (req.op == OP_KEY);
	assign is_data   = in_fire && (req.op == OP_DATA);
	assign key_room  = count_q < CNT_MAX;

	// A key byte is stored only while there is room in the key RAM. A last
	// byte that completes a key of legal length starts the schedule.
	assign key_wr      = is_key && key_room;
	assign start_data  = is_data && keyed_q;
	assign start_sched = is_key && req.key_last && key_room;

	assign eng_req.start_data  = start_data;
	assign eng_req.start_sched = start_sched;
	assign eng_req.data_byte   = req.byte_in;

	assign out_free = !out_v_q || rsp.ready;

	// Result of the current cycle: either the engine has finished, or the
	// accepted item is answered at once (plain key byte, overlong key, or
	// data while no key is loaded).
	always_comb begin
		res_v    = 1'b0;
		res_byte = '0;
		res_stat = STAT_DATA_OK;
		priority if (st_q == T_RUN && eng_rsp.done) begin
			res_v    = 1'b1;
			res_byte = eng_rsp.out_byte;
			res_stat = sched_q ? STAT_KEY_OK : STAT_DATA_OK;
		end else if (is_data && !keyed_q) begin
			res_v    = 1'b1;
			res_stat = STAT_NO_KEY;
		end else if (is_key && !start_sched) begin
			res_v    = 1'b1;
			res_stat = key_room ? STAT_KEY_OK : STAT_KEY_LONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= T_IDLE;
			keyed_q <= 1'b0;
			count_q <= '0;
			sched_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			// Every key byte drops the current key. The last byte clears the
			// counter whether or not the key was usable, so the next byte
			// starts a fresh key.
			if (is_key) begin
				keyed_q <= 1'b0;
				if (req.key_last) begin
					count_q <= '0;
				end else if (key_room) begin
					count_q <= CNT_W'(count_q + CNT_W'(1));
				end else begin
					count_q <= CNT_OVF;
				end
			end
			if (st_q == T_RUN && eng_rsp.done && sched_q) begin
				keyed_q <= 1'b1;
			end

			unique case (st_q)
				T_IDLE: begin
					if (start_data || start_sched) begin
						sched_q <= start_sched;
						st_q    <= T_RUN;
					end else if (res_v && !out_free) begin
						st_q <= T_PEND;
					end
				end
				T_RUN: begin
					if (eng_rsp.done) begin
						st_q <= out_free ? T_IDLE : T_PEND;
					end
				end
				T_PEND: begin
					if (out_free) begin
						st_q <= T_IDLE;
					end
				end
				default: begin
					st_q <= T_IDLE;
				end
			endcase

			if (res_v && !out_free) begin
				pend_byte_q <= res_byte;
				pend_stat_q <= res_stat;
			end

			if (res_v && out_free) begin
				out_v_q    <= 1'b1;
				out_byte_q <= res_byte;
				out_stat_q <= res_stat;
			end else if (st_q == T_PEND && out_free) begin
				out_v_q    <= 1'b1;
				out_byte_q <= pend_byte_q;
				out_stat_q <= pend_stat_q;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign rsp.valid    = out_v_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.status   = out_stat_q;

	// Key bytes are written at the running count; the engine reads them back
	// cyclically during the schedule.
	rc4_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(KEY_MAX)
	) u_key_ram (
		.clk  (clk),
		.we   (key_wr),
		.waddr(count_q[KS_AW-1:0]),
		.wdata(req.byte_in),
		.raddr(key_raddr),
		.rdata(key_rdata)
	);

	rc4_engine #(
		.KS_AW(KS_AW),
		.CNT_W(CNT_W)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (eng_req),
		.key_len  (CNT_W'(count_q + CNT_W'(1))),
		.key_raddr(key_raddr),
		.key_rdata(key_rdata),
		.rsp      (eng_rsp)
	);

	// The engine only reports completion of work that this sequencer started.
	`RC4_ASSERT_IMP(a_done_in_run, eng_rsp.done, st_q == T_RUN, "engine done outside a run")
	// A finished key schedule leaves the cipher keyed.
	`RC4_ASSERT_NXT(a_keyed_after_sched, st_q == T_RUN && eng_rsp.done && sched_q, keyed_q,
		"cipher not keyed after schedule")
	// The key counter saturates at the overflow mark.
	`RC4_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_OVF, "key counter out of range")
	// A parked result moves to the output as soon as the output frees up.
	`RC4_ASSERT_NXT(a_pend_drains, st_q == T_PEND && out_free, out_v_q && st_q == T_IDLE,
		"pending result not delivered")

endmodule

[verif/rc4_stream_cipher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Drives key and data items into the cipher over its request channel and
// checks every result item against a cycle-free model of the key schedule
// and keystream. A directed opening covers the corner cases. Random key/data
// sequences then run under four sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_tb;
	import rc4_pkg::*;

	// The block is built with its full key size, so the key store index wraps
	// exactly as it does in a deployed part.
	localparam int KEY_LIMIT = 256;

	// One key schedule is a fill of all 256 entries plus 256 swap steps.
	// After the last result, this many cycles let any schedule still running
	// finish before the run ends.
	localparam int DRAIN_CYCLES = 1500;

	// Least random item count of each idle phase; the two long keys come on top.
	localparam int PHASE_ITEMS = 4;

	// One result item as the cipher returns it.
	typedef struct packed {
		byte_t      out_byte;
		logic [1:0] status;
	} cipher_result_t;

	// Keeps its own copy of the permutation, the indices and the key being
	// loaded, and queues the result that each accepted item must produce.
	class keystream_board;
		byte_t          sbox [SBOX_DEPTH];
		byte_t          key_bytes [SBOX_DEPTH];
		byte_t          idx_i;
		byte_t          idx_j;
		logic [8:0]     key_len;
		bit             keyed;
		cipher_result_t expected_results[$];
		int             errors;
		int             checked;
		int             schedules;
		int             status_seen [4];

		function new();
			idx_i     = '0;
			idx_j     = '0;
			key_len   = '0;
			keyed     = 1'b0;
			errors    = 0;
			checked   = 0;
			schedules = 0;
			foreach (status_seen[s])
				status_seen[s] = 0;
		endfunction

		function void note_item(logic op, byte_t b, logic last);
			cipher_result_t r;
			byte_t          acc;
			byte_t          t;
			r.out_byte = '0;
			if (op == OP_DATA) begin
				if (!keyed) begin
					r.status = STAT_NO_KEY;
				end else begin
					// One keystream step: advance i and j, swap, then look up.
					idx_i = idx_i + 8'd1;
					idx_j = idx_j + sbox[idx_i];
					t = sbox[idx_i];
					sbox[idx_i] = sbox[idx_j];
					sbox[idx_j] = t;
					t = sbox[idx_i] + sbox[idx_j];
					r.out_byte = b ^ sbox[t];
					r.status = STAT_DATA_OK;
				end
			end else begin
				keyed = 1'b0;
				if (key_len < KEY_LIMIT) begin
					key_bytes[key_len[7:0]] = b;
					key_len = key_len + 9'd1;
					r.status = STAT_KEY_OK;
				end else begin
					key_len = 9'(KEY_LIMIT + 1);
					r.status = STAT_KEY_LONG;
				end
				if (last) begin
					if (r.status == STAT_KEY_OK) begin
						// Key schedule: identity, then swaps cycling through the key.
						for (int n = 0; n < SBOX_DEPTH; n++)
							sbox[n] = byte_t'(n);
						acc = '0;
						for (int n = 0; n < SBOX_DEPTH; n++) begin
							acc = acc + sbox[n] + key_bytes[byte_t'(n % key_len)];
							t = sbox[n];
							sbox[n] = sbox[acc];
							sbox[acc] = t;
						end
						idx_i = '0;
						idx_j = '0;
						keyed = 1'b1;
						schedules++;
					end
					key_len = '0;
				end
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(byte_t out_byte, logic [1:0] status);
			cipher_result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, no item waiting: out_byte %02h status %0d",
					$time, out_byte, status);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			checked++;
			status_seen[want.status]++;
			if (out_byte !== want.out_byte) begin
				$display("%0t: out_byte mismatch: expected %02h, actual %02h",
					$time, want.out_byte, out_byte);
				errors++;
			end
			if (status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, want.status, status);
				errors++;
			end
		endfunction

		function int waiting();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rc4_req_if req_ch ();
	rc4_rsp_if rsp_ch ();

	keystream_board board;

	// Idle percentages of the sender and the receiver, set per phase.
	int tx_idle_pct;
	int rx_stall_pct;
	int items_sent;

	rc4_stream_cipher #(
		.KEY_MAX(KEY_LIMIT)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	// The receiver decides its ready once per cycle at the falling edge, so the
	// value is stable when the cipher samples it at the rising edge.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// Both channels are observed at the rising edge. Values seen here are the
	// ones from before the edge, so the order of events inside the step does
	// not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				board.note_item(req_ch.op, req_ch.byte_in, req_ch.key_last);
			if (rsp_ch.valid && rsp_ch.ready)
				board.check_result(rsp_ch.out_byte, rsp_ch.status);
		end
	end

	// Called at a falling edge; returns at the falling edge after the item has
	// been accepted. While the sender idles, valid is low and the payload
	// keeps changing to random values.
	task automatic send_item(logic op, byte_t b, logic last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid   <= 1'b0;
			req_ch.byte_in <= byte_t'($urandom);
			req_ch.op      <= 1'($urandom);
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.byte_in  <= b;
		req_ch.key_last <= last;
		do
			@(posedge clk);
		while (!req_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// A key of len random bytes. With close set the final byte carries
	// key_last and starts the schedule; without it the key is left open.
	task automatic send_key(int len, bit close);
		for (int k = 0; k < len; k++)
			send_item(OP_KEY, byte_t'($urandom), close && (k == len - 1));
	endtask

	// Data items ignore key_last, so it is randomized on them.
	task automatic send_data(int n);
		repeat (n)
			send_item(OP_DATA, byte_t'($urandom), 1'($urandom));
	endtask

	// One random sequence. Most load a complete key, at times a single byte,
	// and then a data burst on its new keystream; the rest continue the stream,
	// send data while unkeyed, or leave a key open before its last byte.
	task automatic send_random_sequence();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			if ($urandom_range(0, 9) == 0)
				send_key($urandom_range(17, 64), 1'b1);
			else
				send_key($urandom_range(1, 16), 1'b1);
			send_data($urandom_range(1, 24));
		end else if (pick < 82) begin
			send_data($urandom_range(1, 8));
		end else if (pick < 92) begin
			send_key($urandom_range(1, 4), 1'b0);
			send_data($urandom_range(1, 3));
		end else begin
			send_key(1, 1'b1);
			send_data($urandom_range(1, 4));
		end
	endtask

	initial begin
		int phase_start;
		int tx_pct [4];
		int rx_pct [4];

		board        = new();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		items_sent   = 0;
		tx_pct       = '{0, 46, 0, 22};
		rx_pct       = '{0, 0, 46, 22};

		// Every input of the block is known from time zero.
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.op       = OP_KEY;
		req_ch.byte_in  = '0;
		req_ch.key_last = 1'b0;
		rsp_ch.ready    = 1'b0;

		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening, with no idling on either side.
		// Data before any key has been loaded, with and without key_last set.
		send_item(OP_DATA, 8'h00, 1'b0);
		send_item(OP_DATA, 8'hFF, 1'b1);
		// Shortest key, a single zero byte, then extreme data bytes.
		send_item(OP_KEY, 8'h00, 1'b1);
		send_item(OP_DATA, 8'h00, 1'b0);
		send_item(OP_DATA, 8'hFF, 1'b0);
		// A classic three-byte text key and the start of its plaintext.
		send_item(OP_KEY, 8'h4B, 1'b0);
		send_item(OP_KEY, 8'h65, 1'b0);
		send_item(OP_KEY, 8'h79, 1'b1);
		send_item(OP_DATA, 8'h50, 1'b0);
		send_item(OP_DATA, 8'h6C, 1'b1);
		send_item(OP_DATA, 8'h61, 1'b0);
		send_item(OP_DATA, 8'h69, 1'b0);
		// A key byte without key_last unkeys the cipher, so data is refused
		// until the key is closed; the open byte becomes part of the next key.
		send_item(OP_KEY, 8'hFF, 1'b0);
		send_item(OP_DATA, 8'hA5, 1'b0);
		send_item(OP_KEY, 8'h01, 1'b1);
		send_item(OP_DATA, 8'h5A, 1'b0);
		send_item(OP_DATA, 8'hC3, 1'b0);
		// Rekeying in the middle of a stream restarts it from the new key.
		send_item(OP_KEY, 8'h80, 1'b1);
		send_item(OP_DATA, 8'h55, 1'b0);
		send_item(OP_DATA, 8'hAA, 1'b1);

		// Random part, in four idle patterns. Phase one also carries a key of
		// exactly the maximum length; phase three carries a key one byte past
		// the limit, whose closing byte is rejected and which leaves the
		// cipher unkeyed until a fresh key arrives.
		for (int p = 0; p < 4; p++) begin
			tx_idle_pct  = tx_pct[p];
			rx_stall_pct = rx_pct[p];
			if (p == 1) begin
				send_key(KEY_LIMIT, 1'b1);
				send_data($urandom_range(2, 4));
			end
			if (p == 3) begin
				send_key(KEY_LIMIT + 1, 1'b1);
				send_data($urandom_range(1, 2));
				send_key($urandom_range(1, 4), 1'b1);
				send_data($urandom_range(2, 4));
			end
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				send_random_sequence();
		end
		req_ch.valid <= 1'b0;

		// Drain: the receiver stops stalling, every expected result must come,
		// and a trailing schedule gets time to finish so any stray result shows.
		rx_stall_pct = 0;
		while (board.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Sent %0d items in four idle patterns; %0d checked, %0d keys scheduled.",
			items_sent, board.checked, board.schedules);
		$display("Status counts: data ok %0d, key byte %0d, key too long %0d, no key %0d.",
			board.status_seen[STAT_DATA_OK], board.status_seen[STAT_KEY_OK],
			board.status_seen[STAT_KEY_LONG], board.status_seen[STAT_NO_KEY]);
		if (board.errors == 0 && board.waiting() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, even with every schedule
	// and every stall at its worst.
	initial begin
		#4000000;
		$display("Timeout: %0d results still waiting", board.waiting());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
